@@ hw/rtl/rfo_pkg.sv @@
// Shared types and constants for the ring FIFO with overwrite.
`timescale 1ns / 1ps
`default_nettype none

package rfo_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = 4;
  localparam int MODE_W     = 3;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QIDX_W = 1;
  localparam int QCNT_W = 2;

  // Request mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 3'd0,
    MODE_GET   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_DUMP  = 3'd3,
    MODE_CLEAR = 3'd4
  } rfo_mode_t;

  // Classified operations handed to the back end
  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUMP  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_BAD   = 3'd5
  } rfo_op_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [DATA_WIDTH-1:0] data_in;
  } rfo_in_t;

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] data_out;
    logic                  dropped_oldest;
    logic [CNT_W-1:0]      elem_count;
    logic                  is_empty;
    logic                  is_full;
    logic                  last;
  } rfo_out_t;

  typedef struct packed {
    rfo_op_t               op;
    logic [DATA_WIDTH-1:0] data;
  } rfo_cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    rfo_cmd_t cmd;
  } rfo_q_head_t;

endpackage

`default_nettype wire

@@ hw/rtl/rfo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rfo_front.sv @@
// Front end: accept requests, classify the mode and queue commands.
`timescale 1ns / 1ps
`default_nettype none

module rfo_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire rfo_pkg::rfo_in_t in_req,
  output rfo_pkg::rfo_q_head_t head,
  input  wire logic            pop
);
  import rfo_pkg::*;

  rfo_cmd_t          q_r [QDEPTH];
  logic [QIDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [QIDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;
  rfo_cmd_t          cmd;

  assign busy   = (cnt_r == QCNT_W'(QDEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  // Classify the request mode
  always_comb begin
    cmd.data = in_req.data_in;
    unique case (in_req.mode)
      MODE_PUT:   cmd.op = OP_PUT;
      MODE_GET:   cmd.op = OP_GET;
      MODE_PEEK:  cmd.op = OP_PEEK;
      MODE_DUMP:  cmd.op = OP_DUMP;
      MODE_CLEAR: cmd.op = OP_CLEAR;
      default:    cmd.op = OP_BAD;
    endcase
  end

  // Advance queue indexes and count
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
    end
    if (do_pop) begin
      rd_idx_nxt = (rd_idx_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified request
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_idx_r];

endmodule

`default_nettype wire

@@ hw/rtl/rfo_back.sv @@
// Back end: execute queued commands against the ring store and emit results.
`timescale 1ns / 1ps
`default_nettype none

module rfo_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rfo_pkg::rfo_q_head_t head,
  output logic                      pop,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  output logic                      out_strobe,
  output rfo_pkg::rfo_out_t         out_res
);
  import rfo_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DUMP = 3'b100
  } rfo_state_t;

  rfo_state_t            state_r, state_nxt;
  logic [PTR_W-1:0]      rp_r, rp_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [PTR_W-1:0]      dp_r, dp_nxt;
  logic                  is_get_r, is_get_nxt;
  logic                  ow_r;
  logic                  vld_r, vld_nxt;
  rfo_out_t              res_r, res_nxt;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  empty;
  logic                  full;
  logic [PTR_W-1:0]      dp_inc;

  // Build a result from status after the operation
  function automatic rfo_out_t make_res(input logic ok, input logic [DATA_WIDTH-1:0] data,
                                        input logic dropped, input logic last_flag,
                                        input logic [PTR_W-1:0] rp,
                                        input logic [PTR_W-1:0] wp);
    rfo_out_t         r;
    logic [PTR_W-1:0] n;
    n                = wp - rp;
    r.ok             = ok;
    r.data_out       = data;
    r.dropped_oldest = dropped;
    r.elem_count     = CNT_W'(n);
    r.is_empty       = (n == '0);
    r.is_full        = (n == PTR_W'(DEPTH - 1));
    r.last           = last_flag;
    return r;
  endfunction

  assign empty  = (rp_r == wp_r);
  assign full   = ((wp_r + 1'b1) == rp_r);
  assign dp_inc = dp_r + 1'b1;
  assign pop    = (state_r == ST_IDLE) && head.valid;

  // Slot store
  rfo_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(head.cmd.data),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Execute commands
  always_comb begin
    state_nxt  = state_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    dp_nxt     = dp_r;
    is_get_nxt = is_get_r;
    vld_nxt    = 1'b0;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_raddr  = (state_r == ST_DUMP) ? dp_inc : rp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          vld_nxt = 1'b1;
          unique case (head.cmd.op) inside
            OP_PUT: begin
              if (full && !ow_r) begin
                res_nxt = make_res(1'b0, '0, 1'b0, 1'b1, rp_r, wp_r);
              end else begin
                ram_we = 1'b1;
                wp_nxt = wp_r + 1'b1;
                if (full) begin
                  rp_nxt = rp_r + 1'b1;
                end
                res_nxt = make_res(1'b1, '0, full, 1'b1, rp_nxt, wp_nxt);
              end
            end
            OP_GET, OP_PEEK: begin
              if (empty) begin
                res_nxt = make_res(1'b0, '0, 1'b0, 1'b1, rp_r, wp_r);
              end else begin
                vld_nxt    = 1'b0;
                is_get_nxt = (head.cmd.op == OP_GET);
                state_nxt  = ST_READ;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                res_nxt = make_res(1'b0, '0, 1'b0, 1'b1, rp_r, wp_r);
              end else begin
                vld_nxt   = 1'b0;
                dp_nxt    = rp_r;
                state_nxt = ST_DUMP;
              end
            end
            OP_CLEAR: begin
              rp_nxt  = '0;
              wp_nxt  = '0;
              res_nxt = make_res(1'b1, '0, 1'b0, 1'b1, '0, '0);
            end
            default: begin
              res_nxt = make_res(1'b0, '0, 1'b0, 1'b1, rp_r, wp_r);
            end
          endcase
        end
      end
      ST_READ: begin
        // Read data for the oldest slot is ready
        if (is_get_r) begin
          rp_nxt = rp_r + 1'b1;
        end
        vld_nxt   = 1'b1;
        res_nxt   = make_res(1'b1, ram_rdata, 1'b0, 1'b1, rp_nxt, wp_r);
        state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        // Emit one element a cycle, prefetching the next slot
        vld_nxt = 1'b1;
        res_nxt = make_res(1'b1, ram_rdata, 1'b0, (dp_inc == wp_r), rp_r, wp_r);
        dp_nxt  = dp_inc;
        if (dp_inc == wp_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      ow_r    <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      vld_r   <= vld_nxt;
      if (cfg_we) begin
        ow_r <= cfg_wdata;
      end
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    dp_r     <= dp_nxt;
    is_get_r <= is_get_nxt;
    res_r    <= res_nxt;
  end

  assign out_strobe = vld_r;
  assign out_res    = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/ring_fifo_overwrite_top.sv @@
// Top level of the ring FIFO with overwrite: front end, back end and config port.
// Flow (back end idle): each request is registered in the command queue; put, clear and
//   refused ones then give a registered result; get and peek hold the back end in ST_READ,
//   and dump in ST_DUMP, which gives one element a cycle. Puts and clears run one a cycle
//   while the back end is idle; the two-entry queue takes two requests; busy is high when full.
// Reset (rst_n low, synchronous): read/write pointers zero, overwrite off, queue empty; no output stall.
`timescale 1ns / 1ps
`default_nettype none

module ring_fifo_overwrite_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rfo_pkg::rfo_in_t  in_req,
  output logic                   out_strobe,
  output rfo_pkg::rfo_out_t      out_res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);
  import rfo_pkg::*;

  rfo_q_head_t head;
  logic        pop;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  rfo_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .in_req(in_req),
    .head  (head),
    .pop   (pop)
  );

  rfo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
